FILE: sv/srm_pkg.sv
`timescale 1ns / 1ps

package srm_pkg;

  // Frame layout
  localparam int HEADER_BYTES = 8;
  localparam int HDR_CNT_W    = $clog2(HEADER_BYTES + 1);

  // Queue between the front and back parts
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // SLIP framing bytes
  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_COMMAND   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_DIRECTION = 1'd1;

  localparam logic [7:0] EXPECTED_COMMAND_RST   = 8'h00;
  localparam logic [7:0] RESPONSE_DIRECTION_RST = 8'h01;

  typedef enum logic [1:0] {
    OP_BYTE      = 2'd0,
    OP_TIMEOUT   = 2'd1,
    OP_READ_FAIL = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    RC_OK          = 3'd0,
    RC_TIMEOUT     = 3'd1,
    RC_READ_FAIL   = 3'd2,
    RC_BAD_ESCAPE  = 3'd3,
    RC_DEVICE_FAIL = 3'd4
  } result_code_t;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_SKIP   = 3'd1,
    PH_HEADER = 3'd2,
    PH_STATUS = 3'd3,
    PH_TAIL   = 3'd4
  } phase_t;

  // Classified transaction held in the queue
  typedef struct packed {
    opcode_t    kind;
    logic [7:0] byte_val;
    logic       is_end;
    logic       is_esc;
    logic       esc_ok;
    logic [7:0] esc_val;
  } srm_item_t;

  typedef struct packed {
    logic [7:0] expected_command;
    logic [7:0] response_direction;
  } srm_cfg_t;

endpackage

FILE: sv/srm_in_if.sv
`timescale 1ns / 1ps

interface srm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;

  modport source (output valid, opcode, rx_byte, input ready);
  modport sink   (input valid, opcode, rx_byte, output ready);
endinterface

FILE: sv/srm_out_if.sv
`timescale 1ns / 1ps

interface srm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_code;
  logic [7:0] device_error;

  modport source (output valid, result_code, device_error, input ready);
  modport sink   (input valid, result_code, device_error, output ready);
endinterface

FILE: sv/srm_front.sv
`timescale 1ns / 1ps

module srm_front (
  srm_in_if.sink             byte_ch,
  output logic               q_valid,
  input  logic               q_ready,
  output srm_pkg::srm_item_t q_item
);

  // Accept whenever the queue has room; drop the unused opcode
  assign byte_ch.ready = q_ready;
  assign q_valid = byte_ch.valid &&
                   ((byte_ch.opcode == srm_pkg::OP_BYTE) ||
                    (byte_ch.opcode == srm_pkg::OP_TIMEOUT) ||
                    (byte_ch.opcode == srm_pkg::OP_READ_FAIL));

  // Classify the byte and resolve its escaped meaning up front
  always_comb begin
    q_item          = '0;
    q_item.kind     = srm_pkg::opcode_t'(byte_ch.opcode);
    q_item.byte_val = byte_ch.rx_byte;
    q_item.is_end   = (byte_ch.rx_byte == srm_pkg::SLIP_END);
    q_item.is_esc   = (byte_ch.rx_byte == srm_pkg::SLIP_ESC);
    if (byte_ch.rx_byte == srm_pkg::SLIP_ESC_END) begin
      q_item.esc_ok  = 1'b1;
      q_item.esc_val = srm_pkg::SLIP_END;
    end else if (byte_ch.rx_byte == srm_pkg::SLIP_ESC_ESC) begin
      q_item.esc_ok  = 1'b1;
      q_item.esc_val = srm_pkg::SLIP_ESC;
    end
  end

endmodule

FILE: sv/srm_queue.sv
`timescale 1ns / 1ps

module srm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  srm_pkg::srm_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output srm_pkg::srm_item_t pop_item
);

  srm_pkg::srm_item_t entries [srm_pkg::QUEUE_DEPTH];
  logic [srm_pkg::QPTR_W-1:0] wr_ptr;
  logic [srm_pkg::QPTR_W-1:0] rd_ptr;
  logic [srm_pkg::QCNT_W-1:0] count;
  logic push_fire;
  logic pop_fire;

  assign push_ready = (count != srm_pkg::QCNT_W'(srm_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == srm_pkg::QPTR_W'(srm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == srm_pkg::QPTR_W'(srm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the incoming transaction
  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: sv/srm_back.sv
`timescale 1ns / 1ps

module srm_back (
  input  logic               clk,
  input  logic               rst,
  input  srm_pkg::srm_cfg_t  cfg,
  input  logic               q_valid,
  output logic               q_ready,
  input  srm_pkg::srm_item_t q_item,
  srm_out_if.source          result_ch
);

  srm_pkg::phase_t phase, phase_next;
  logic [srm_pkg::HDR_CNT_W-1:0] hdr_cnt, hdr_cnt_next;
  logic esc_pend, esc_pend_next;
  logic st_cnt, st_cnt_next;
  logic [7:0] dir_seen, dir_seen_next;
  logic [7:0] cmd_seen, cmd_seen_next;
  logic [7:0] failed_flag, failed_flag_next;
  logic [7:0] error_code, error_code_next;

  logic                   rsp_valid;
  srm_pkg::result_code_t  rsp_code;
  logic [7:0]             rsp_err;

  logic                   fire;
  logic                   emit;
  srm_pkg::result_code_t  emit_code;
  logic [7:0]             emit_err;
  logic                   store_hdr;
  logic                   store_st;
  logic                   clear;
  logic [7:0]             store_val;
  logic                   match;

  // Take a transaction only when the output register can hold its result
  assign q_ready = !rsp_valid || result_ch.ready;
  assign fire    = q_valid && q_ready;

  assign match = (hdr_cnt >= srm_pkg::HDR_CNT_W'(2)) &&
                 (dir_seen == cfg.response_direction) &&
                 (cmd_seen == cfg.expected_command);

  // Parse one transaction
  always_comb begin
    phase_next       = phase;
    hdr_cnt_next     = hdr_cnt;
    esc_pend_next    = esc_pend;
    st_cnt_next      = st_cnt;
    dir_seen_next    = dir_seen;
    cmd_seen_next    = cmd_seen;
    failed_flag_next = failed_flag;
    error_code_next  = error_code;
    emit      = 1'b0;
    emit_code = srm_pkg::RC_OK;
    emit_err  = '0;
    store_hdr = 1'b0;
    store_st  = 1'b0;
    clear     = 1'b0;
    store_val = q_item.byte_val;

    if (fire) begin
      unique case (q_item.kind)
        srm_pkg::OP_TIMEOUT: begin
          emit      = 1'b1;
          emit_code = srm_pkg::RC_TIMEOUT;
          clear     = 1'b1;
        end
        srm_pkg::OP_READ_FAIL: begin
          emit      = 1'b1;
          emit_code = srm_pkg::RC_READ_FAIL;
          clear     = 1'b1;
        end
        srm_pkg::OP_BYTE: begin
          unique case (phase)
            srm_pkg::PH_HUNT: begin
              if (q_item.is_end) begin
                phase_next = srm_pkg::PH_SKIP;
              end
            end
            srm_pkg::PH_SKIP: begin
              if (!q_item.is_end) begin
                phase_next = srm_pkg::PH_HEADER;
                if (q_item.is_esc) begin
                  esc_pend_next = 1'b1;
                end else begin
                  store_hdr = 1'b1;
                end
              end
            end
            srm_pkg::PH_HEADER: begin
              if (esc_pend) begin
                esc_pend_next = 1'b0;
                if (!q_item.esc_ok) begin
                  emit      = 1'b1;
                  emit_code = srm_pkg::RC_BAD_ESCAPE;
                  clear     = 1'b1;
                end else begin
                  store_hdr = 1'b1;
                  store_val = q_item.esc_val;
                end
              end else if (q_item.is_esc) begin
                esc_pend_next = 1'b1;
              end else if (q_item.is_end) begin
                phase_next = srm_pkg::PH_STATUS;
              end else begin
                store_hdr = 1'b1;
              end
            end
            srm_pkg::PH_STATUS: begin
              // A bare delimiter counts as a plain status byte here
              if (esc_pend) begin
                esc_pend_next = 1'b0;
                if (!q_item.esc_ok) begin
                  emit      = 1'b1;
                  emit_code = srm_pkg::RC_BAD_ESCAPE;
                  clear     = 1'b1;
                end else begin
                  store_st  = 1'b1;
                  store_val = q_item.esc_val;
                end
              end else if (q_item.is_esc) begin
                esc_pend_next = 1'b1;
              end else begin
                store_st = 1'b1;
              end
            end
            srm_pkg::PH_TAIL: begin
              if (q_item.is_end) begin
                clear = 1'b1;
                if (match) begin
                  emit = 1'b1;
                  if (failed_flag != '0) begin
                    emit_code = srm_pkg::RC_DEVICE_FAIL;
                    emit_err  = error_code;
                  end
                end
              end
            end
            default: begin
              clear = 1'b1;
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    // Keep direction and command, count the rest of the header
    if (store_hdr) begin
      if (hdr_cnt == '0) begin
        dir_seen_next = store_val;
      end
      if (hdr_cnt == srm_pkg::HDR_CNT_W'(1)) begin
        cmd_seen_next = store_val;
      end
      hdr_cnt_next = hdr_cnt + 1'b1;
      if (hdr_cnt_next >= srm_pkg::HDR_CNT_W'(srm_pkg::HEADER_BYTES)) begin
        phase_next = srm_pkg::PH_STATUS;
      end
    end

    if (store_st) begin
      if (!st_cnt) begin
        failed_flag_next = store_val;
        st_cnt_next      = 1'b1;
      end else begin
        error_code_next = store_val;
        st_cnt_next     = 1'b0;
        phase_next      = srm_pkg::PH_TAIL;
      end
    end

    // End of exchange: return to hunting
    if (clear) begin
      phase_next    = srm_pkg::PH_HUNT;
      hdr_cnt_next  = '0;
      esc_pend_next = 1'b0;
      st_cnt_next   = 1'b0;
    end
  end

  // Hold parser control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= srm_pkg::PH_HUNT;
      hdr_cnt  <= '0;
      esc_pend <= 1'b0;
      st_cnt   <= 1'b0;
    end else begin
      phase    <= phase_next;
      hdr_cnt  <= hdr_cnt_next;
      esc_pend <= esc_pend_next;
      st_cnt   <= st_cnt_next;
    end
  end

  // Captured frame bytes; each is written before it is compared
  always_ff @(posedge clk) begin
    dir_seen    <= dir_seen_next;
    cmd_seen    <= cmd_seen_next;
    failed_flag <= failed_flag_next;
    error_code  <= error_code_next;
  end

  // Output register: load a new result or drop the one taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (result_ch.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp_code <= emit_code;
      rsp_err  <= emit_err;
    end
  end

  assign result_ch.valid        = rsp_valid;
  assign result_ch.result_code  = rsp_code;
  assign result_ch.device_error = rsp_err;

endmodule

FILE: sv/slip_response_matcher_top.sv
`timescale 1ns / 1ps
// Path: the accepting edge writes the queue, and the output register is loaded from
// it once that register is free to hold the result of the accepted transaction.
// Throughput: one transaction per cycle while results are taken; a two-entry queue
// lets the front keep accepting while the back waits on the output register.
// Reset: synchronous active-high rst empties queue and output, returns the parser to
// hunting and sets expected_command to 0 and response_direction to 1.

module slip_response_matcher_top (
  input  logic                          clk,
  input  logic                          rst,
  srm_in_if.sink                        byte_ch,
  srm_out_if.source                     result_ch,
  input  logic                          cfg_we,
  input  logic [srm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata
);

  srm_pkg::srm_cfg_t  cfg;
  logic               push_valid;
  logic               push_ready;
  srm_pkg::srm_item_t push_item;
  logic               pop_valid;
  logic               pop_ready;
  srm_pkg::srm_item_t pop_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_command   <= srm_pkg::EXPECTED_COMMAND_RST;
      cfg.response_direction <= srm_pkg::RESPONSE_DIRECTION_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srm_pkg::CFG_EXPECTED_COMMAND:   cfg.expected_command   <= cfg_wdata;
        srm_pkg::CFG_RESPONSE_DIRECTION: cfg.response_direction <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  srm_front u_front (
    .byte_ch (byte_ch),
    .q_valid (push_valid),
    .q_ready (push_ready),
    .q_item  (push_item)
  );

  srm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  srm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_item    (pop_item),
    .result_ch (result_ch)
  );

  // A timeout taken by the back part is reported on the next cycle
  a_timeout_reported: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready && (pop_item.kind == srm_pkg::OP_TIMEOUT)) |=>
      (result_ch.valid && (result_ch.result_code == srm_pkg::RC_TIMEOUT)))
    else $error("timeout transaction did not produce a timeout result");

  // A read failure taken by the back part is reported on the next cycle
  a_read_fail_reported: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready && (pop_item.kind == srm_pkg::OP_READ_FAIL)) |=>
      (result_ch.valid && (result_ch.result_code == srm_pkg::RC_READ_FAIL)))
    else $error("read failure transaction did not produce a read failure result");

  // Only a device failure carries an error code
  a_error_only_on_fail: assert property (@(posedge clk) disable iff (rst)
    (result_ch.valid && (result_ch.result_code != srm_pkg::RC_DEVICE_FAIL)) |->
      (result_ch.device_error == 8'h00))
    else $error("device_error set on a result other than device failure");

endmodule

FILE: dv/slip_response_matcher_top_tb.sv
`timescale 1ns / 1ps

module slip_response_matcher_top_tb;
  import srm_pkg::*;

  // Opcode value that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 300;
  localparam int N_PHASES    = 6;
  localparam int N_DIRECTED  = 25;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] b;
  } stim_t;

  typedef struct packed {
    result_code_t code;
    logic [7:0]   dev;
  } result_t;

  typedef struct packed {
    logic [1:0]   op;
    logic [7:0]   b;
    logic         pinned;
    result_code_t code;
    logic [7:0]   dev;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_wdata;

  srm_in_if  byte_ch();
  srm_out_if result_ch();

  slip_response_matcher_top dut (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Travels with each transaction: a result fixed by hand overrides the prediction
  logic         cur_pinned;
  result_code_t cur_pin_code;
  logic [7:0]   cur_pin_dev;

  result_t pending_results[$];
  stim_t   frame_q[$];
  int      n_fail = 0;
  bit      in_burst = 1'b0;
  bit      out_burst = 1'b0;

  // Parser copy: registers and frame state
  logic [7:0] want_cmd = EXPECTED_COMMAND_RST;
  logic [7:0] want_dir = RESPONSE_DIRECTION_RST;
  phase_t     m_phase = PH_HUNT;
  int         m_hdr_cnt = 0;
  bit         m_esc = 1'b0;
  int         m_stat_cnt = 0;
  logic [7:0] m_dir = 8'h00;
  logic [7:0] m_cmd = 8'h00;
  logic [7:0] m_failed = 8'h00;
  logic [7:0] m_err = 8'h00;

  // Directed frames under the reset register values (command 0x00, direction 0x01)
  directed_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{OP_TIMEOUT,   8'h00, 1'b1, RC_TIMEOUT,    8'h00},  // timeout while hunting
    '{OP_UNUSED,    8'hFF, 1'b0, RC_OK,         8'h00},  // ignored opcode
    '{OP_BYTE,      8'hC0, 1'b0, RC_OK,         8'h00},
    '{OP_BYTE,      8'hC0, 1'b0, RC_OK,         8'h00},  // repeated delimiter
    '{OP_BYTE,      8'hDB, 1'b0, RC_OK,         8'h00},  // escaped first header byte
    '{OP_BYTE,      8'hDC, 1'b0, RC_OK,         8'h00},
    '{OP_BYTE,      8'hC0, 1'b0, RC_OK,         8'h00},  // header cut before command
    '{OP_BYTE,      8'hC0, 1'b0, RC_OK,         8'h00},  // delimiter as status byte
    '{OP_BYTE,      8'h00, 1'b0, RC_OK,         8'h00},
    '{OP_BYTE,      8'hC0, 1'b0, RC_OK,         8'h00},  // mismatch, hunt again
    '{OP_BYTE,      8'hC0, 1'b0, RC_OK,         8'h00},
    '{OP_BYTE,      8'h01, 1'b0, RC_OK,         8'h00},
    '{OP_BYTE,      8'h00, 1'b0, RC_OK,         8'h00},
    '{OP_BYTE,      8'hC0, 1'b0, RC_OK,         8'h00},
    '{OP_BYTE,      8'hDB, 1'b0, RC_OK,         8'h00},
    '{OP_BYTE,      8'hC0, 1'b1, RC_BAD_ESCAPE, 8'h00},  // delimiter after escape
    '{OP_BYTE,      8'hC0, 1'b0, RC_OK,         8'h00},
    '{OP_BYTE,      8'h01, 1'b0, RC_OK,         8'h00},
    '{OP_BYTE,      8'h00, 1'b0, RC_OK,         8'h00},
    '{OP_BYTE,      8'hC0, 1'b0, RC_OK,         8'h00},
    '{OP_BYTE,      8'h00, 1'b0, RC_OK,         8'h00},
    '{OP_BYTE,      8'hFF, 1'b0, RC_OK,         8'h00},
    '{OP_BYTE,      8'hC0, 1'b1, RC_OK,         8'h00},  // matching frame, no failure
    '{OP_BYTE,      8'hC0, 1'b0, RC_OK,         8'h00},
    '{OP_READ_FAIL, 8'h00, 1'b1, RC_READ_FAIL,  8'h00}   // read failure mid-frame
  };

  function automatic void clear_exchange();
    m_phase    = PH_HUNT;
    m_hdr_cnt  = 0;
    m_esc      = 1'b0;
    m_stat_cnt = 0;
    m_dir      = 8'h00;
    m_cmd      = 8'h00;
    m_failed   = 8'h00;
    m_err      = 8'h00;
  endfunction

  function automatic void take_header(input logic [7:0] v);
    if (m_hdr_cnt == 0) m_dir = v;
    else if (m_hdr_cnt == 1) m_cmd = v;
    if (m_hdr_cnt < 255) m_hdr_cnt++;
    if (m_hdr_cnt >= HEADER_BYTES) m_phase = PH_STATUS;
  endfunction

  function automatic void take_status(input logic [7:0] v);
    if (m_stat_cnt == 0) m_failed = v;
    else m_err = v;
    m_stat_cnt++;
    if (m_stat_cnt >= 2) m_phase = PH_TAIL;
  endfunction

  // Advance the parser copy by one transaction and report any result it ends with
  function automatic void parse_transaction(input logic [1:0] op, input logic [7:0] b,
                                            output bit got, output result_t res);
    bit in_hdr;
    logic [7:0] v;
    got = 1'b0;
    res = '{RC_OK, 8'h00};
    in_hdr = (m_phase == PH_HEADER);
    if (op == OP_TIMEOUT) begin
      got = 1'b1;
      res.code = RC_TIMEOUT;
    end else if (op == OP_READ_FAIL) begin
      got = 1'b1;
      res.code = RC_READ_FAIL;
    end else if (op == OP_BYTE) begin
      case (m_phase)
        PH_HUNT: begin
          if (b == SLIP_END) m_phase = PH_SKIP;
        end
        PH_SKIP: begin
          if (b != SLIP_END) begin
            m_phase = PH_HEADER;
            if (b == SLIP_ESC) m_esc = 1'b1;
            else take_header(b);
          end
        end
        PH_HEADER, PH_STATUS: begin
          if (m_esc) begin
            m_esc = 1'b0;
            if (b == SLIP_ESC_END || b == SLIP_ESC_ESC) begin
              v = (b == SLIP_ESC_END) ? SLIP_END : SLIP_ESC;
              if (in_hdr) take_header(v);
              else take_status(v);
            end else begin
              got = 1'b1;
              res.code = RC_BAD_ESCAPE;
            end
          end else if (b == SLIP_ESC) begin
            m_esc = 1'b1;
          end else if (in_hdr && b == SLIP_END) begin
            m_phase = PH_STATUS;
          end else if (in_hdr) begin
            take_header(b);
          end else begin
            take_status(b);
          end
        end
        PH_TAIL: begin
          if (b == SLIP_END) begin
            if (m_hdr_cnt >= 2 && m_dir == want_dir && m_cmd == want_cmd) begin
              got = 1'b1;
              if (m_failed != 8'h00) res = '{RC_DEVICE_FAIL, m_err};
            end else begin
              clear_exchange();
            end
          end
        end
        default: clear_exchange();
      endcase
    end
    if (got) clear_exchange();
  endfunction

  // Predict on accepted input, check on accepted output
  always @(posedge clk) begin : watch
    bit got;
    result_t res;
    result_t want;
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready) begin
        parse_transaction(byte_ch.opcode, byte_ch.rx_byte, got, res);
        if (cur_pinned) pending_results.push_back('{cur_pin_code, cur_pin_dev});
        else if (got) pending_results.push_back(res);
      end
      if (result_ch.valid && result_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: result_code %0d device_error %0h",
                 result_ch.result_code, result_ch.device_error);
          n_fail++;
        end else begin
          want = pending_results.pop_front();
          if (result_ch.result_code !== want.code) begin
            $error("result_code: expected %0d, got %0d", want.code, result_ch.result_code);
            n_fail++;
          end
          if (result_ch.device_error !== want.dev) begin
            $error("device_error: expected %0h, got %0h", want.dev, result_ch.device_error);
            n_fail++;
          end
        end
      end
    end
  end

  // Result side: random hold-off per result, one long hold to back the block up
  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    result_ch.ready <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = ~out_burst;
      hold = out_burst ? 0 : $urandom_range(0, 17);
      if (taken == 30) hold = 500;
      if (hold > 0) begin
        result_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
      taken++;
    end
  end

  // Offer one transaction after a random gap and hold it until taken
  task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic pin,
                           input result_code_t pcode, input logic [7:0] pdev);
    int gap;
    if ($urandom_range(0, 39) == 0) in_burst = ~in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.opcode  <= op;
    byte_ch.rx_byte <= b;
    cur_pinned      <= pin;
    cur_pin_code    <= pcode;
    cur_pin_dev     <= pdev;
    do @(posedge clk); while (!(byte_ch.valid && byte_ch.ready));
  endtask

  // Drop valid and wait until every expected result is in and the pipeline is empty
  task automatic settle();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_match(input logic [7:0] cmd, input logic [7:0] dir);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_EXPECTED_COMMAND;
    cfg_wdata <= cmd;
    @(posedge clk);
    cfg_index <= CFG_RESPONSE_DIRECTION;
    cfg_wdata <= dir;
    @(posedge clk);
    cfg_we   <= 1'b0;
    want_cmd = cmd;
    want_dir = dir;
  endtask

  function automatic void push_byte(input logic [7:0] v);
    frame_q.push_back('{OP_BYTE, v});
  endfunction

  function automatic void put_escaped(input logic [7:0] v);
    if (v == SLIP_END) begin
      push_byte(SLIP_ESC);
      push_byte(SLIP_ESC_END);
    end else if (v == SLIP_ESC) begin
      push_byte(SLIP_ESC);
      push_byte(SLIP_ESC_ESC);
    end else begin
      push_byte(v);
    end
  endfunction

  // Build one frame into frame_q: mostly well formed, some noise and broken frames
  task automatic build_frame();
    int n_hdr;
    int roll;
    int pos;
    bit match;
    bit short_hdr;
    logic [7:0] v;
    logic [7:0] bad;
    logic [1:0] op;
    frame_q.delete();
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // Line noise: plain bytes or the unused opcode
      repeat ($urandom_range(1, 6)) begin
        op = ($urandom_range(0, 3) == 0) ? OP_UNUSED : OP_BYTE;
        frame_q.push_back('{op, 8'($urandom_range(0, 255))});
      end
    end else begin
      match = ($urandom_range(0, 99) < 65);
      short_hdr = ($urandom_range(0, 9) == 0);
      n_hdr = short_hdr ? $urandom_range(1, HEADER_BYTES - 1) : HEADER_BYTES;
      repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
      repeat ($urandom_range(1, 3)) push_byte(SLIP_END);
      for (int i = 0; i < n_hdr; i++) begin
        v = 8'($urandom_range(0, 255));
        if (match && i == 0) v = want_dir;
        if (match && i == 1) v = want_cmd;
        put_escaped(v);
      end
      if (short_hdr) push_byte(SLIP_END);
      // Status: failure flag then error code; a delimiter may go in unescaped
      for (int i = 0; i < 2; i++) begin
        v = (i == 0 && $urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 5) == 0) v = SLIP_END;
        if (v == SLIP_END && $urandom_range(0, 1) == 0) push_byte(v);
        else put_escaped(v);
      end
      repeat ($urandom_range(0, 2)) begin
        v = 8'($urandom_range(0, 255));
        if (v == SLIP_END) v = 8'h3F;
        push_byte(v);
      end
      push_byte(SLIP_END);
      // Break the frame now and then
      roll = $urandom_range(0, 99);
      pos = $urandom_range(0, frame_q.size() - 1);
      if (roll < 8) begin
        do bad = 8'($urandom_range(0, 255));
        while (bad == SLIP_ESC_END || bad == SLIP_ESC_ESC);
        frame_q.insert(pos, '{OP_BYTE, bad});
        frame_q.insert(pos, '{OP_BYTE, SLIP_ESC});
      end else if (roll < 14) begin
        op = ($urandom_range(0, 1) == 0) ? OP_TIMEOUT : OP_READ_FAIL;
        frame_q.insert(pos, '{op, 8'($urandom_range(0, 255))});
      end else if (roll < 17) begin
        frame_q.insert(pos, '{OP_UNUSED, 8'($urandom_range(0, 255))});
      end
    end
  endtask

  initial begin : stimulus
    int sent;
    logic [7:0] ph_cmd [0:N_PHASES-1];
    logic [7:0] ph_dir [0:N_PHASES-1];
    directed_row_t row;
    ph_cmd = '{8'h00, 8'hFF, 8'hC0, 8'h00, 8'hDB, 8'h00};
    ph_dir = '{8'h00, 8'hFF, 8'hDB, 8'h01, 8'hC0, 8'h00};
    ph_cmd[3] = 8'($urandom_range(0, 255));
    ph_dir[5] = 8'($urandom_range(0, 255));
    byte_ch.valid   <= 1'b0;
    byte_ch.opcode  <= OP_BYTE;
    byte_ch.rx_byte <= 8'h00;
    cur_pinned      <= 1'b0;
    cur_pin_code    <= RC_OK;
    cur_pin_dev     <= 8'h00;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_EXPECTED_COMMAND;
    cfg_wdata       <= 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under reset register values
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_rows[i];
      send_item(row.op, row.b, row.pinned, row.code, row.dev);
    end
    settle();

    // Random frames, one register setting per phase
    for (int p = 0; p < N_PHASES; p++) begin
      set_match(ph_cmd[p], ph_dir[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_frame();
        foreach (frame_q[i]) begin
          send_item(frame_q[i].op, frame_q[i].b, 1'b0, RC_OK, 8'h00);
          if (frame_q[i].op != OP_UNUSED) sent++;
        end
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin : watchdog
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
